// ===== src/dst_pkg.sv =====
// Package for the dedup set table: request codes and the control word
// that the top level sends to every storage cell. No dependencies.
package dst_pkg;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef struct packed {
    logic cmp;    // compare cell contents against the request value
    logic ins;    // append: the cell at position count loads the value
    logic shift;  // remove: cells at or above the hit take their neighbor's value
  } cell_ctrl_t;

endpackage

// ===== src/dst_cell.sv =====
// One storage cell of the dedup set table: holds one entry, compares it,
// and loads either the request value or its upper neighbor's entry. Uses dst_pkg.
module dst_cell #(
  parameter int IDX = 0,
  parameter int IW  = 7,
  parameter int CW  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dst_pkg::cell_ctrl_t ctrl_i,
  input  logic [CW-1:0]       count_i,
  input  logic [IW-1:0]       pos_i,
  input  logic signed [31:0]  cmp_value_i,
  input  logic signed [31:0]  ins_value_i,
  input  logic signed [31:0]  next_value_i,
  output logic signed [31:0]  value_o,
  output logic                hit_o
);
  import dst_pkg::*;

  logic signed [31:0] value_q;
  logic               hit_q;
  logic               occupied;

  assign occupied = CW'(IDX) < count_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.cmp) begin
      hit_q <= occupied && (value_q == cmp_value_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins && (CW'(IDX) == count_i)) begin
      value_q <= ins_value_i;
    end else if (ctrl_i.shift && (IW'(IDX) >= pos_i)) begin
      value_q <= next_value_i;
    end
  end

  assign value_o = value_q;
  assign hit_o   = hit_q;

endmodule

// ===== src/dedup_set_table.sv =====
// Dedup set table top level: request FSM, hit encoder, count and result
// register over a chain of dst_cell storage cells. Uses dst_pkg.
//
//   channel | handshake             | payload
//   --------+-----------------------+----------------------------------------------
//   in      | in_valid_i/in_stall_o | req_type_i, value_i
//   out     | out_valid_o/out_stall_i | done_ok_o, match_found_o, match_index_o,
//           |                       | entry_count_o, full_reject_o
//
// Every cell compares at the accept edge; the update state then encodes the hit and
// appends, shifts the chain down by one, or clears the count.
// The update state waits while a previous result is still stalled at the output.
// Reset empties the set (count to zero); cell contents are not cleared.
module dedup_set_table #(
  parameter int ENTRIES = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               done_ok_o,
  output logic               match_found_o,
  output logic [6:0]         match_index_o,
  output logic [7:0]         entry_count_o,
  output logic               full_reject_o
);
  import dst_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic               state_q, state_d;
  logic [1:0]         req_q;
  logic signed [31:0] value_q;
  logic [CW-1:0]      count_q, count_d;

  logic               out_valid_q;
  logic               done_ok_q, match_found_q, full_reject_q;
  logic [6:0]         match_index_q;
  logic [7:0]         entry_count_q;

  logic               in_fire, upd_fire, out_fire;
  logic [ENTRIES-1:0] hit;
  logic [IW-1:0]      pos;
  logic               found;
  logic               is_full;
  logic               ok, reject, do_ins, do_rem;
  cell_ctrl_t         ctrl;
  logic signed [31:0] cell_value [ENTRIES];
  logic [IW+6:0]      pos_ext;
  logic [CW+7:0]      cnt_ext;

  assign in_stall_o = (state_q == ST_UPD);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && !out_stall_i;
  assign upd_fire   = (state_q == ST_UPD) && !(out_valid_q && out_stall_i);

  always_comb begin
    pos = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit[i]) begin
        pos = pos | IW'(i);
      end
    end
  end

  assign found   = (req_q != REQ_CLEAR) && (|hit);
  assign is_full = (count_q == CW'(ENTRIES));

  always_comb begin
    ok      = 1'b0;
    reject  = 1'b0;
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    count_d = count_q;
    case (req_q)
      REQ_LOOKUP: ok = found;
      REQ_INSERT: begin
        if (!found) begin
          if (!is_full) begin
            do_ins  = 1'b1;
            ok      = 1'b1;
            count_d = count_q + CW'(1);
          end else begin
            reject = 1'b1;
          end
        end
      end
      REQ_REMOVE: begin
        if (found) begin
          do_rem  = 1'b1;
          ok      = 1'b1;
          count_d = count_q - CW'(1);
        end
      end
      default: begin
        ok      = 1'b1;
        count_d = '0;
      end
    endcase
  end

  assign ctrl.cmp   = in_fire;
  assign ctrl.ins   = upd_fire && do_ins;
  assign ctrl.shift = upd_fire && do_rem;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic signed [31:0] next_value;
    if (g == ENTRIES - 1) begin : g_last
      assign next_value = cell_value[g];
    end else begin : g_mid
      assign next_value = cell_value[g+1];
    end
    dst_cell #(
      .IDX(g),
      .IW (IW),
      .CW (CW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .pos_i       (pos),
      .cmp_value_i (value_i),
      .ins_value_i (value_q),
      .next_value_i(next_value),
      .value_o     (cell_value[g]),
      .hit_o       (hit[g])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_UPD;
      ST_UPD:  if (upd_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (upd_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q   <= req_type_i;
      value_q <= value_i;
    end
  end

  assign pos_ext = (IW + 7)'(found ? pos : '0);
  assign cnt_ext = (CW + 8)'(count_d);

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      done_ok_q     <= ok;
      match_found_q <= found;
      match_index_q <= pos_ext[6:0];
      entry_count_q <= cnt_ext[7:0];
      full_reject_q <= reject;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign done_ok_o     = done_ok_q;
  assign match_found_o = match_found_q;
  assign match_index_o = match_index_q;
  assign entry_count_o = entry_count_q;
  assign full_reject_o = full_reject_q;

  a_hit_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit))
    else $error("more than one cell matched");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ENTRIES))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_fire && do_ins |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not grow the set");

  a_reject_not_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_fire && reject |-> is_full && !ok && (req_q == REQ_INSERT))
    else $error("reject outside a full insert");

endmodule
